// ===== hdl/i2da_pkg.sv =====
`timescale 1ns / 1ps

package i2da_pkg;

  localparam int MAX_DIGITS_DEF = 8;
  localparam int MAX_OUT        = 9;
  localparam int NUM_W          = 32;
  localparam int CHAR_W         = 7;
  localparam int DIGIT_W        = 4;
  localparam int LEN_W          = 4;

  localparam logic [LEN_W-1:0] MAX_CHARS_RST = LEN_W'(MAX_OUT);
  localparam logic [LEN_W-1:0] HUGE_LEN      = LEN_W'(5);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

  typedef logic [MAX_OUT-1:0][CHAR_W-1:0] text_t;

  // Huge! from element 0 upwards, padded with NUL
  localparam text_t HUGE_TEXT = {7'h00, 7'h00, 7'h00, 7'h00,
                                 7'h21, 7'h65, 7'h67, 7'h75, 7'h48};

  typedef struct packed {
    logic neg;
    logic huge;
  } num_flags_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 64'd1;
    for (int i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

endpackage

// ===== hdl/int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps

// Converts a signed 32-bit number into its decimal text and sends it out one
// ASCII character per beat on char_code_o, marked by char_valid_o; last_o
// flags the final beat of a value and too_large_o is set on every beat of
// "Huge!", sent when the magnitude reaches 10^MAX_DIGITS. A value is taken at
// a clock edge with start_i high and busy_o low. It then passes the input
// and magnitude registers, one register per digit, the pack register and
// the serialiser, which sends its n characters (1 to 9, cut at max_chars,
// 0 acting as 1 and above 9 as 9). Successive texts follow back to back, so
// the sustained rate is set by the character serialiser; short texts let a
// new value in every cycle. The receiver
// cannot stall: each beat is valid for exactly one cycle. busy_o rises only
// when the conversion pipeline has filled up behind a long text. Write
// max_chars only while no value is in flight.

module int_to_decimal_ascii import i2da_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [NUM_W-1:0] number_i,
  input  logic                    max_chars_we_i,
  input  logic [LEN_W-1:0]        max_chars_i,
  output logic                    char_valid_o,
  output logic [CHAR_W-1:0]       char_code_o,
  output logic                    too_large_o,
  output logic                    last_o
);

  // magnitude width that holds any value below the threshold
  localparam int MAG_W = $clog2(pow10(MAX_DIGITS));

  logic [LEN_W-1:0] max_chars_q, limit;

  // pipeline links: index j feeds digit stage j, index MAX_DIGITS feeds pack
  logic [MAX_DIGITS:0]                st_valid, st_ready;
  num_flags_t                         st_flags  [MAX_DIGITS+1];
  logic [MAG_W-1:0]                   st_value  [MAX_DIGITS+1];
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] st_digits [MAX_DIGITS+1];

  logic             front_ready;
  logic             pk_valid, ser_ready;
  num_flags_t       pk_flags;
  text_t            pk_text;
  logic [LEN_W-1:0] pk_len;

  // character limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= MAX_CHARS_RST;
    end else if (max_chars_we_i) begin
      max_chars_q <= max_chars_i;
    end
  end

  // clamp the limit into one to nine characters
  always_comb begin
    if (max_chars_q == '0)                  limit = LEN_W'(1);
    else if (max_chars_q > LEN_W'(MAX_OUT)) limit = LEN_W'(MAX_OUT);
    else                                    limit = max_chars_q;
  end

  assign busy_o = !front_ready;

  // input register, then sign, magnitude and threshold test
  i2da_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAG_W      (MAG_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i),
    .in_ready_o  (front_ready),
    .number_i    (number_i),
    .out_valid_o (st_valid[0]),
    .out_ready_i (st_ready[0]),
    .flags_o     (st_flags[0]),
    .mag_o       (st_value[0])
  );

  assign st_digits[0] = '0;

  // one decimal digit per stage, most significant first
  for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_digit
    i2da_digit #(
      .MAX_DIGITS (MAX_DIGITS),
      .MAG_W      (MAG_W),
      .STAGE      (j)
    ) u_digit (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[j]),
      .in_ready_o  (st_ready[j]),
      .flags_i     (st_flags[j]),
      .value_i     (st_value[j]),
      .digits_i    (st_digits[j]),
      .out_valid_o (st_valid[j+1]),
      .out_ready_i (st_ready[j+1]),
      .flags_o     (st_flags[j+1]),
      .value_o     (st_value[j+1]),
      .digits_o    (st_digits[j+1])
    );
  end

  // drop leading zeros, add the sign, cut at the limit
  i2da_pack #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .in_valid_i  (st_valid[MAX_DIGITS]),
    .in_ready_o  (st_ready[MAX_DIGITS]),
    .flags_i     (st_flags[MAX_DIGITS]),
    .digits_i    (st_digits[MAX_DIGITS]),
    .out_valid_o (pk_valid),
    .out_ready_i (ser_ready),
    .flags_o     (pk_flags),
    .text_o      (pk_text),
    .len_o       (pk_len)
  );

  // advance one character per beat
  i2da_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pk_valid),
    .in_ready_o   (ser_ready),
    .flags_i      (pk_flags),
    .text_i       (pk_text),
    .len_i        (pk_len),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .too_large_o  (too_large_o),
    .last_o       (last_o)
  );

endmodule

// ===== hdl/i2da_front.sv =====
`timescale 1ns / 1ps

module i2da_front import i2da_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAG_W      = 27
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [NUM_W-1:0] number_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output num_flags_t              flags_o,
  output logic [MAG_W-1:0]        mag_o
);

  localparam logic [NUM_W-1:0] THRESH = NUM_W'(pow10(MAX_DIGITS));

  logic                    num_vld_q;
  logic signed [NUM_W-1:0] number_q;
  logic                    mag_vld_q;
  num_flags_t              flags_q, flags_d;
  logic [MAG_W-1:0]        mag_q;
  logic [NUM_W-1:0]        raw, abs_val;
  logic                    mag_ready;

  assign mag_ready  = !mag_vld_q || out_ready_i;
  assign in_ready_o = !num_vld_q || mag_ready;

  // sign and magnitude; the most negative value lands on 2^31, always huge
  always_comb begin
    raw           = number_q;
    abs_val       = raw[NUM_W-1] ? (~raw + NUM_W'(1)) : raw;
    flags_d.neg   = raw[NUM_W-1];
    flags_d.huge  = (abs_val >= THRESH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vld_q <= 1'b0;
      mag_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) num_vld_q <= in_valid_i;
      if (mag_ready)  mag_vld_q <= num_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) number_q <= number_i;
    if (num_vld_q && mag_ready) begin
      flags_q <= flags_d;
      mag_q   <= abs_val[MAG_W-1:0];
    end
  end

  assign out_valid_o = mag_vld_q;
  assign flags_o     = flags_q;
  assign mag_o       = mag_q;

endmodule

// ===== hdl/i2da_digit.sv =====
`timescale 1ns / 1ps

module i2da_digit import i2da_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAG_W      = 27,
  parameter int STAGE      = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  num_flags_t                          flags_i,
  input  logic [MAG_W-1:0]                    value_i,
  input  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output num_flags_t                          flags_o,
  output logic [MAG_W-1:0]                    value_o,
  output logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_o
);

  localparam longint unsigned WEIGHT = pow10(MAX_DIGITS - 1 - STAGE);

  logic                               valid_q;
  num_flags_t                         flags_q;
  logic [MAG_W-1:0]                   value_q, value_d, sub;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_q, digits_d;
  logic [DIGIT_W-1:0]                 digit;

  assign in_ready_o = !valid_q || out_ready_i;

  // take the digit at this weight: largest multiple that still fits
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int i = 1; i <= 9; i++) begin
      if (value_i >= MAG_W'(WEIGHT * longint'(i))) begin
        digit = DIGIT_W'(i);
        sub   = MAG_W'(WEIGHT * longint'(i));
      end
    end
    value_d         = value_i - sub;
    digits_d        = digits_i;
    digits_d[STAGE] = digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      flags_q  <= flags_i;
      value_q  <= value_d;
      digits_q <= digits_d;
    end
  end

  assign out_valid_o = valid_q;
  assign flags_o     = flags_q;
  assign value_o     = value_q;
  assign digits_o    = digits_q;

endmodule

// ===== hdl/i2da_pack.sv =====
`timescale 1ns / 1ps

module i2da_pack import i2da_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [LEN_W-1:0]                    limit_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  num_flags_t                          flags_i,
  input  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output num_flags_t                          flags_o,
  output text_t                               text_o,
  output logic [LEN_W-1:0]                    len_o
);

  logic             valid_q;
  num_flags_t       flags_q;
  text_t            text_q, text_d;
  logic [LEN_W-1:0] len_q, len_d, full_len, lz, nd;
  logic             found;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    // count leading zeros, keeping at least one digit
    lz    = '0;
    found = 1'b0;
    for (int j = 0; j < MAX_DIGITS - 1; j++) begin
      if (!found) begin
        if (digits_i[j] == '0) lz = lz + LEN_W'(1);
        else                   found = 1'b1;
      end
    end
    nd = LEN_W'(MAX_DIGITS) - lz;

    for (int p = 0; p < MAX_OUT; p++) begin
      text_d[p] = '0;
      if (flags_i.neg && p == 0) begin
        text_d[p] = CH_MINUS;
      end else begin
        for (int j = 0; j < MAX_DIGITS; j++) begin
          if (int'(lz) + p - int'(flags_i.neg) == j) begin
            text_d[p] = CH_ZERO + CHAR_W'(digits_i[j]);
          end
        end
      end
    end
    if (flags_i.huge) text_d = HUGE_TEXT;

    full_len = flags_i.huge ? HUGE_LEN : (nd + LEN_W'(flags_i.neg));
    len_d    = (full_len > limit_i) ? limit_i : full_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      flags_q <= flags_i;
      text_q  <= text_d;
      len_q   <= len_d;
    end
  end

  assign out_valid_o = valid_q;
  assign flags_o     = flags_q;
  assign text_o      = text_q;
  assign len_o       = len_q;

endmodule

// ===== hdl/i2da_serial.sv =====
`timescale 1ns / 1ps

module i2da_serial import i2da_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  num_flags_t        flags_i,
  input  text_t             text_i,
  input  logic [LEN_W-1:0]  len_i,
  output logic              char_valid_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              too_large_o,
  output logic              last_o
);

  logic             valid_q;
  logic [LEN_W-1:0] cnt_q;
  text_t            text_q;
  logic             huge_q;
  logic             load;

  // free again on the last beat, so the next text follows without a gap
  assign in_ready_o = !valid_q || (cnt_q == LEN_W'(1));
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      cnt_q   <= len_i;
    end else if (valid_q) begin
      valid_q <= (cnt_q != LEN_W'(1));
      cnt_q   <= cnt_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      text_q <= text_i;
      huge_q <= flags_i.huge;
    end else if (valid_q) begin
      text_q <= {CHAR_W'(0), text_q[MAX_OUT-1:1]};
    end
  end

  assign char_valid_o = valid_q;
  assign char_code_o  = text_q[0];
  assign too_large_o  = huge_q;
  assign last_o       = valid_q && (cnt_q == LEN_W'(1));

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> cnt_q != '0)
    else $error("serialiser active with empty count");

  a_stop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_o && !in_valid_i) |=> !char_valid_o)
    else $error("beat emitted after last without new text");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && !last_o) |=> (char_valid_o && $stable(too_large_o)))
    else $error("text run broken before its last beat");

  a_no_early_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && !last_o) |-> !in_ready_o)
    else $error("serialiser ready in the middle of a run");

endmodule

// ===== dv/int_to_decimal_ascii_checker.sv =====
`timescale 1ns / 1ps

// Watches the number and character channels of int_to_decimal_ascii, predicts
// the text of every accepted value and compares each character beat in order.

module int_to_decimal_ascii_checker import i2da_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [NUM_W-1:0]  number_i,
  input  logic              max_chars_we_i,
  input  logic [LEN_W-1:0]  max_chars_i,
  input  logic              char_valid_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic              too_large_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                beats_o
);

  localparam logic [5*8-1:0] HUGE_WORD = "Huge!";

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              too_large;
    logic              last;
  } char_beat_t;

  char_beat_t       expected_chars [$];
  logic [LEN_W-1:0] max_chars_q;

  // Queue the characters that one value turns into under the current limit.
  function automatic void spell_number(input logic [NUM_W-1:0] num);
    logic [CHAR_W-1:0] text [12];
    logic [CHAR_W-1:0] digits [10];
    longint unsigned   mag;
    longint unsigned   threshold;
    int                len;
    int                nd;
    int                n;
    int                lim;
    logic              huge;
    char_beat_t        beat;
    len       = 0;
    nd        = 0;
    threshold = 1;
    for (int i = 0; i < MAX_DIGITS && i < 9; i++) threshold = threshold * 10;
    mag  = num[NUM_W-1] ? (64'h1_0000_0000 - 64'(num)) : 64'(num);
    huge = (mag >= threshold);
    if (huge) begin
      for (int k = 0; k < 5; k++) begin
        text[len] = HUGE_WORD[(4-k)*8 +: CHAR_W];
        len = len + 1;
      end
    end else begin
      do begin
        digits[nd] = CH_ZERO + CHAR_W'(mag % 64'd10);
        nd  = nd + 1;
        mag = mag / 64'd10;
      end while (mag != 0);
      if (num[NUM_W-1]) begin
        text[len] = CH_MINUS;
        len = len + 1;
      end
      while (nd > 0) begin
        nd = nd - 1;
        text[len] = digits[nd];
        len = len + 1;
      end
    end
    // a limit of zero still lets one character out, above nine acts as nine
    lim = int'(max_chars_q);
    if (lim == 0) lim = 1;
    if (lim > MAX_OUT) lim = MAX_OUT;
    n = (len > lim) ? lim : len;
    for (int k = 0; k < n; k++) begin
      beat.code      = text[k];
      beat.too_large = huge;
      beat.last      = (k == n - 1);
      expected_chars.insert(expected_chars.size(), beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_beat_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      max_chars_q  = MAX_CHARS_RST;
      fail_count_o = 0;
      beats_o      = 0;
    end else begin
      if (char_valid_i) begin
        beats_o = beats_o + 1;
        if (expected_chars.size() == 0) begin
          $display("%0t: char beat with nothing expected: code 0x%02h too_large %0b last %0b",
                   $time, char_code_i, too_large_i, last_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_chars.pop_front();
          if (char_code_i !== want.code) begin
            $display("%0t: char_code expected 0x%02h actual 0x%02h",
                     $time, want.code, char_code_i);
            fail_count_o = fail_count_o + 1;
          end
          if (too_large_i !== want.too_large) begin
            $display("%0t: too_large expected %0b actual %0b",
                     $time, want.too_large, too_large_i);
            fail_count_o = fail_count_o + 1;
          end
          if (last_i !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (max_chars_we_i) max_chars_q = max_chars_i;
      if (start_i && !busy_i) spell_number(number_i);
    end
    pending_o = expected_chars.size();
  end

endmodule

// ===== dv/tb_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for int_to_decimal_ascii. The checker beside the DUT
// predicts and compares every character beat; this module only feeds numbers,
// moves max_chars between phases and decides pass or fail.

module tb_int_to_decimal_ascii;
  import i2da_pkg::*;

  // Pipeline depth plus the longest text, with some margin: quiet time to
  // allow after the last expected beat before touching max_chars or ending.
  localparam int SETTLE_CYCLES = MAX_DIGITS_DEF + 3 + MAX_OUT + 4;
  // Far above the slowest legal run (159 values).
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int PHASE_ITEMS   = 17;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [NUM_W-1:0]  number_i;
  logic              max_chars_we_i;
  logic [LEN_W-1:0]  max_chars_i;
  logic              char_valid_o;
  logic [CHAR_W-1:0] char_code_o;
  logic              too_large_o;
  logic              last_o;

  int fail_count;
  int pending_chars;
  int beats_seen;
  int cycle_count;
  int values_sent;
  int settings_used;

  int directed_plain [$] = '{0, 1, -1, 9, -9, 10, -10, 7, 1000000, 12345678, -12345678,
                             99999999, -99999999, 100000000, -100000000,
                             2147483647, -2147483647 - 1};
  int limit_plan [$] = '{1, 4, 0, 9, 15, 10, 6, 9};

  int_to_decimal_ascii u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .number_i       (number_i),
    .max_chars_we_i (max_chars_we_i),
    .max_chars_i    (max_chars_i),
    .char_valid_o   (char_valid_o),
    .char_code_o    (char_code_o),
    .too_large_o    (too_large_o),
    .last_o         (last_o)
  );

  int_to_decimal_ascii_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .number_i       (number_i),
    .max_chars_we_i (max_chars_we_i),
    .max_chars_i    (max_chars_i),
    .char_valid_i   (char_valid_o),
    .char_code_i    (char_code_o),
    .too_large_i    (too_large_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_chars),
    .beats_o        (beats_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a lost beat or a stuck busy ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d characters outstanding",
               $time, pending_chars);
      $display("[int_to_decimal_ascii] ERROR");
      $finish;
    end
  end

  // Present one value from the falling edge and hold it until the block takes
  // it. Back-to-back calls keep start high, so no extra gap is inserted.
  task automatic send_number(input logic [NUM_W-1:0] value);
    @(negedge clk_i);
    start_i  = 1'b1;
    number_i = value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    values_sent++;
  endtask

  // Drop start for a random burst; scramble the number bus meanwhile.
  task automatic idle_burst();
    int gap;
    gap = $urandom_range(1, 6);
    repeat (gap) begin
      @(negedge clk_i);
      start_i  = 1'b0;
      number_i = $urandom;
    end
  endtask

  // Wait until every predicted character has come out, then let the pipeline
  // go quiet.
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_chars != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Change the limit only with nothing in flight.
  task automatic write_max_chars(input logic [LEN_W-1:0] value);
    drain();
    max_chars_we_i = 1'b1;
    max_chars_i    = value;
    @(negedge clk_i);
    max_chars_we_i = 1'b0;
    settings_used++;
  endtask

  // Mix of short texts, full-width noise and values hugging the Huge! threshold.
  function automatic logic [NUM_W-1:0] pick_number();
    int              nd;
    longint unsigned span;
    int              mag;
    span = 1;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1, 2: begin
        nd = $urandom_range(1, 9);
        for (int i = 0; i < nd; i++) span = span * 10;
        mag = $urandom_range(0, 32'(span - 1));
      end
      3: mag = 100000000 + $urandom_range(0, 4) - 2;
      default: mag = $urandom_range(0, 20);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic random_phase(input int count, input bit with_gaps);
    for (int i = 0; i < count; i++) begin
      send_number(pick_number());
      if (with_gaps && $urandom_range(0, 3) == 0) idle_burst();
    end
  endtask

  initial begin
    start_i        = 1'b0;
    number_i       = '0;
    max_chars_we_i = 1'b0;
    max_chars_i    = '0;
    rst_ni         = 1'b0;
    values_sent    = 0;
    settings_used  = 1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed values under the reset limit of nine: zero, single digits,
    // signs, both sides of the threshold, the most negative number.
    foreach (directed_plain[i]) send_number(directed_plain[i]);

    // A limit of zero still emits one character; the top values clamp to nine.
    write_max_chars(4'd0);
    send_number(-5);
    send_number(0);
    send_number(-100000000);
    write_max_chars(4'd15);
    send_number(-2147483647 - 1);
    send_number(-87654321);
    send_number(123456789);

    // Random phases, one per limit; the last one runs without gaps.
    foreach (limit_plan[p]) begin
      write_max_chars(p == 6 ? LEN_W'($urandom_range(2, 8)) : LEN_W'(limit_plan[p]));
      random_phase(PHASE_ITEMS, p != limit_plan.size() - 1);
    end

    drain();
    $display("Converted %0d values under %0d max_chars settings, %0d character beats checked.",
             values_sent, settings_used, beats_seen);
    if (fail_count == 0) begin
      $display("[int_to_decimal_ascii] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[int_to_decimal_ascii] ERROR");
    end
    $finish;
  end

endmodule
